// File: hw/rtl/pfe_pkg.sv
// Shared types, constants and decode helpers for the postfix expression evaluator.
`default_nettype none

package pfe_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DIV_STEPS   = WORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [SYM_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [SYM_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [SYM_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_PCT   = 8'h25;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CHAR  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIV_ZERO  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic is_operand(input logic [SYM_W-1:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
               (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    function automatic op_t decode_op(input logic [SYM_W-1:0] c);
        op_t op;
        unique case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_PCT:   op = OP_MOD;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/postfix_expression_evaluator.sv
// Top level of the postfix expression evaluator: stack, sequencer and result register.
// Operands, bad or skipped characters and operators short of operands finish in S_IDLE;
// + - * and a division by zero also pass S_READ (stack read, then compute); / and % then
// wait in S_DIV for the one-bit-per-cycle divider. A final character adds S_FINISH to load
// the result register, held while an earlier result waits for m_tready. Requests are taken
// only in S_IDLE. Reset (aresetn low, synchronous) empties the stack, clears error, valid.
`default_nettype none

module postfix_expression_evaluator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input requests: one character per request, tlast on the final character.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic        s_tlast,   // final_symbol
    // Results: one per expression.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

    // The top of the stack lives in tos_reg; the entries below it live in the memory,
    // so an operator needs exactly one memory read (the first operand).
    logic [pfe_pkg::WORD_W-1:0] stack_mem [pfe_pkg::STACK_DEPTH];
    logic [pfe_pkg::WORD_W-1:0] rd_data_reg;
    logic [pfe_pkg::ADDR_W-1:0] mem_raddr;
    logic [pfe_pkg::ADDR_W-1:0] mem_waddr;
    logic                       mem_we;

    pfe_pkg::state_t            state_reg, state_next;
    logic [pfe_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [pfe_pkg::CNT_W-1:0]  cnt_m1;
    logic [pfe_pkg::CNT_W-1:0]  cnt_m2;
    logic [pfe_pkg::WORD_W-1:0] tos_reg, tos_next;
    pfe_pkg::status_t           err_reg, err_next;
    pfe_pkg::op_t               op_reg, op_next;
    pfe_pkg::op_t               in_op;
    logic                       last_reg, last_next;

    logic                       out_valid_reg, out_valid_next;
    logic [pfe_pkg::WORD_W-1:0] out_value_reg, out_value_next;
    pfe_pkg::status_t           out_status_reg, out_status_next;

    pfe_pkg::div_req_t          div_req;
    pfe_pkg::div_rsp_t          div_rsp;

    pfe_pkg::state_t            done_state;
    logic [pfe_pkg::WORD_W-1:0] alu_sum;
    logic [pfe_pkg::WORD_W-1:0] alu_diff;
    logic [pfe_pkg::WORD_W-1:0] alu_prod;

    pfe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cnt_m1    = cnt_reg - pfe_pkg::CNT_W'(1);
    assign cnt_m2    = cnt_reg - pfe_pkg::CNT_W'(2);
    assign mem_waddr = cnt_m1[pfe_pkg::ADDR_W-1:0];
    assign in_op     = pfe_pkg::decode_op(s_tdata);

    // First operand comes from the memory, second operand is the top register.
    assign alu_sum  = rd_data_reg + tos_reg;
    assign alu_diff = rd_data_reg - tos_reg;
    assign alu_prod = rd_data_reg * tos_reg;

    assign s_tready = (state_reg == pfe_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_value_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pfe_pkg::S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= pfe_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        tos_next         = tos_reg;
        err_next         = err_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg & ~m_tready;
        out_value_next   = out_value_reg;
        out_status_next  = out_status_reg;
        mem_we           = 1'b0;
        mem_raddr        = cnt_m2[pfe_pkg::ADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = rd_data_reg;
        div_req.divisor  = tos_reg;
        done_state       = last_reg ? pfe_pkg::S_FINISH : pfe_pkg::S_IDLE;

        unique case (state_reg)
            pfe_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? pfe_pkg::S_FINISH : pfe_pkg::S_IDLE;
                    // Once an error is recorded the rest of the expression is skipped.
                    if (err_reg == pfe_pkg::ST_OK) begin
                        if (pfe_pkg::is_operand(s_tdata)) begin
                            if (cnt_reg >= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH)) begin
                                err_next = pfe_pkg::ST_OVERFLOW;
                            end else begin
                                mem_we   = (cnt_reg != '0);
                                tos_next = {{(pfe_pkg::WORD_W-pfe_pkg::SYM_W){1'b0}}, s_tdata}
                                           - pfe_pkg::WORD_W'(pfe_pkg::CH_ZERO);
                                cnt_next = cnt_reg + pfe_pkg::CNT_W'(1);
                            end
                        end else if (in_op == pfe_pkg::OP_NONE) begin
                            err_next = pfe_pkg::ST_BAD_CHAR;
                        end else if (cnt_reg < pfe_pkg::CNT_W'(2)) begin
                            err_next = pfe_pkg::ST_UNDERFLOW;
                        end else begin
                            op_next    = in_op;
                            state_next = pfe_pkg::S_READ;
                        end
                    end
                end
            end

            pfe_pkg::S_READ: begin
                state_next = done_state;
                unique case (op_reg)
                    pfe_pkg::OP_ADD: begin
                        tos_next = alu_sum;
                        cnt_next = cnt_m1;
                    end
                    pfe_pkg::OP_SUB: begin
                        tos_next = alu_diff;
                        cnt_next = cnt_m1;
                    end
                    pfe_pkg::OP_MUL: begin
                        tos_next = alu_prod;
                        cnt_next = cnt_m1;
                    end
                    pfe_pkg::OP_DIV, pfe_pkg::OP_MOD: begin
                        if (tos_reg == '0) begin
                            err_next = pfe_pkg::ST_DIV_ZERO;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = pfe_pkg::S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            pfe_pkg::S_DIV: begin
                if (div_rsp.done) begin
                    tos_next   = (op_reg == pfe_pkg::OP_MOD) ? div_rsp.remainder
                                                             : div_rsp.quotient;
                    cnt_next   = cnt_m1;
                    state_next = done_state;
                end
            end

            pfe_pkg::S_FINISH: begin
                // Wait for the result register to be free, then report and empty the stack.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    if (err_reg != pfe_pkg::ST_OK) begin
                        out_status_next = err_reg;
                        out_value_next  = '0;
                    end else if (cnt_reg == '0) begin
                        out_status_next = pfe_pkg::ST_UNDERFLOW;
                        out_value_next  = '0;
                    end else begin
                        out_status_next = pfe_pkg::ST_OK;
                        out_value_next  = tos_reg;
                    end
                    cnt_next   = '0;
                    err_next   = pfe_pkg::ST_OK;
                    state_next = pfe_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = pfe_pkg::S_IDLE;
            end
        endcase
    end

    // The stack never holds more than its depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // A reported error always carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != pfe_pkg::ST_OK) |-> out_value_reg == '0)
        else $error("nonzero value with error status");

    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> div_req.divisor != '0)
        else $error("divider started with zero divisor");

    // A recorded error holds until the result is reported.
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != pfe_pkg::ST_OK && state_reg != pfe_pkg::S_FINISH)
        |=> err_reg == $past(err_reg))
        else $error("error code changed before the end of the expression");

endmodule

`default_nettype wire

// File: hw/rtl/pfe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module pfe_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pfe_pkg::div_req_t req,
    output pfe_pkg::div_rsp_t      rsp
);

    logic [pfe_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [pfe_pkg::WORD_W-1:0] quo_reg, quo_next;
    logic [pfe_pkg::WORD_W-1:0] dvs_reg;
    logic [pfe_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       neg_q_reg;
    logic                       neg_r_reg;

    logic [pfe_pkg::WORD_W:0]   shifted;
    logic [pfe_pkg::WORD_W:0]   diff;
    logic [pfe_pkg::WORD_W-1:0] a_mag;
    logic [pfe_pkg::WORD_W-1:0] b_mag;

    assign a_mag = req.dividend[pfe_pkg::WORD_W-1] ? -req.dividend : req.dividend;
    assign b_mag = req.divisor[pfe_pkg::WORD_W-1]  ? -req.divisor  : req.divisor;

    // Restoring step: bring down the next dividend bit and try the subtraction.
    always_comb begin
        shifted = {rem_reg, quo_reg[pfe_pkg::WORD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        if (!diff[pfe_pkg::WORD_W]) begin
            rem_next = diff[pfe_pkg::WORD_W-1:0];
            quo_next = {quo_reg[pfe_pkg::WORD_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[pfe_pkg::WORD_W-1:0];
            quo_next = {quo_reg[pfe_pkg::WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == pfe_pkg::STEP_W'(pfe_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg   <= '0;
            quo_reg   <= a_mag;
            dvs_reg   <= b_mag;
            step_reg  <= '0;
            neg_q_reg <= req.dividend[pfe_pkg::WORD_W-1] ^ req.divisor[pfe_pkg::WORD_W-1];
            neg_r_reg <= req.dividend[pfe_pkg::WORD_W-1];
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg + pfe_pkg::STEP_W'(1);
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_q_reg ? -quo_reg : quo_reg;
    assign rsp.remainder = neg_r_reg ? -rem_reg : rem_reg;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the postfix expression evaluator with a scoreboard class.
`default_nettype none

module testbench;

    localparam logic [pfe_pkg::WORD_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam int unsigned TARGET_REQUESTS = 1850;

    typedef struct packed {
        logic [pfe_pkg::WORD_W-1:0] value;
        pfe_pkg::status_t           status;
    } outcome_t;

    // Mirrors the operand stack and the sticky error, and keeps the results
    // that are still owed by the block in arrival order.
    class postfix_scoreboard;
        logic [pfe_pkg::WORD_W-1:0] operands [pfe_pkg::STACK_DEPTH];
        int unsigned       fill;
        pfe_pkg::status_t  sticky_status;
        outcome_t          pending_outcomes [$];
        int unsigned       mismatches;
        int unsigned       results_seen;
        int unsigned       live_symbols;
        int unsigned       accepted_requests;
        int unsigned       status_hits [5];

        function new();
            fill              = 0;
            sticky_status     = pfe_pkg::ST_OK;
            mismatches        = 0;
            results_seen      = 0;
            live_symbols      = 0;
            accepted_requests = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function bit is_value_char(logic [pfe_pkg::SYM_W-1:0] c);
            return (c >= pfe_pkg::CH_ZERO && c <= pfe_pkg::CH_NINE) ||
                   (c >= pfe_pkg::CH_UP_A && c <= pfe_pkg::CH_UP_Z) ||
                   (c >= pfe_pkg::CH_LO_A && c <= pfe_pkg::CH_LO_Z);
        endfunction

        function pfe_pkg::op_t operator_of(logic [pfe_pkg::SYM_W-1:0] c);
            case (c)
                pfe_pkg::CH_PLUS:  return pfe_pkg::OP_ADD;
                pfe_pkg::CH_MINUS: return pfe_pkg::OP_SUB;
                pfe_pkg::CH_STAR:  return pfe_pkg::OP_MUL;
                pfe_pkg::CH_SLASH: return pfe_pkg::OP_DIV;
                pfe_pkg::CH_PCT:   return pfe_pkg::OP_MOD;
                default:           return pfe_pkg::OP_NONE;
            endcase
        endfunction

        // Called for every accepted request; queues a result on the last character.
        function void apply_request(logic [pfe_pkg::SYM_W-1:0] c, logic last_flag);
            logic [pfe_pkg::WORD_W-1:0] top;
            logic [pfe_pkg::WORD_W-1:0] below;
            logic [pfe_pkg::WORD_W-1:0] res;
            pfe_pkg::op_t               op;
            outcome_t                   outcome;
            accepted_requests++;
            if (sticky_status == pfe_pkg::ST_OK) begin
                live_symbols++;
                op = operator_of(c);
                if (is_value_char(c)) begin
                    if (fill >= pfe_pkg::STACK_DEPTH) begin
                        sticky_status = pfe_pkg::ST_OVERFLOW;
                    end else begin
                        operands[fill] = {24'd0, c} - {24'd0, pfe_pkg::CH_ZERO};
                        fill++;
                    end
                end else if (op == pfe_pkg::OP_NONE) begin
                    sticky_status = pfe_pkg::ST_BAD_CHAR;
                end else if (fill < 2) begin
                    sticky_status = pfe_pkg::ST_UNDERFLOW;
                end else begin
                    top   = operands[fill-1];
                    below = operands[fill-2];
                    if ((op == pfe_pkg::OP_DIV || op == pfe_pkg::OP_MOD) && top == '0) begin
                        sticky_status = pfe_pkg::ST_DIV_ZERO;
                    end else begin
                        case (op)
                            pfe_pkg::OP_ADD: res = below + top;
                            pfe_pkg::OP_SUB: res = below - top;
                            pfe_pkg::OP_MUL: res = below * top;
                            pfe_pkg::OP_DIV: begin
                                // The most negative value over -1 wraps back onto itself.
                                if (below == MOST_NEG && top == '1) res = MOST_NEG;
                                else res = $signed(below) / $signed(top);
                            end
                            default: begin
                                if (below == MOST_NEG && top == '1) res = '0;
                                else res = $signed(below) % $signed(top);
                            end
                        endcase
                        fill--;
                        operands[fill-1] = res;
                    end
                end
            end
            if (last_flag) begin
                outcome.status = sticky_status;
                outcome.value  = '0;
                if (sticky_status == pfe_pkg::ST_OK) begin
                    if (fill == 0) outcome.status = pfe_pkg::ST_UNDERFLOW;
                    else outcome.value = operands[fill-1];
                end
                pending_outcomes.push_back(outcome);
                fill          = 0;
                sticky_status = pfe_pkg::ST_OK;
            end
        endfunction

        function void check_result(logic [39:0] word);
            outcome_t                   want;
            logic [pfe_pkg::WORD_W-1:0] got_value;
            logic [2:0]                 got_status;
            got_value  = word[31:0];
            got_status = word[34:32];
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result with none pending, value %h status %0d",
                         $time, got_value, got_status);
            end else begin
                want = pending_outcomes.pop_front();
                status_hits[int'(want.status)]++;
                if (got_value !== want.value) begin
                    mismatches++;
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want.value, got_value);
                end
                if (got_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, got_status);
                end
                if (word[39:35] !== 5'd0) begin
                    mismatches++;
                    $display("%0t: padding mismatch, expected %h actual %h",
                             $time, 5'd0, word[39:35]);
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [39:0] m_tdata;

    postfix_scoreboard board = new();

    logic [pfe_pkg::SYM_W-1:0] expr_chars [$];
    bit               steady;
    int unsigned      exprs_sent;
    int unsigned      ready_hold;

    always #10 aclk = ~aclk;

    postfix_expression_evaluator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Result side: ready alternates between long open windows and stalls that
    // are mostly short and now and then long.
    always @(negedge aclk) begin
        int unsigned r;
        if (ready_hold == 0) begin
            r = $urandom % 100;
            if (r < 50) begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(1, 40);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(1, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(8, 30);
            end
        end else begin
            ready_hold--;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom % 100;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Entered and left at a falling edge; holds the request until it is taken.
    task automatic send_request(logic [pfe_pkg::SYM_W-1:0] c, logic last_flag);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last_flag;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.apply_request(c, last_flag);
        @(negedge aclk);
    endtask

    task automatic send_expression();
        foreach (expr_chars[i]) send_request(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
        exprs_sent++;
        steady = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [pfe_pkg::SYM_W-1:0] random_operand();
        int unsigned r;
        r = $urandom % 10;
        if (r == 0) return pfe_pkg::CH_ZERO;
        if (r < 4) return pfe_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        if (r < 7) return pfe_pkg::CH_UP_A + 8'($urandom_range(0, 25));
        return pfe_pkg::CH_LO_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [pfe_pkg::SYM_W-1:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return pfe_pkg::CH_PLUS;
            1:       return pfe_pkg::CH_MINUS;
            2:       return pfe_pkg::CH_STAR;
            3:       return pfe_pkg::CH_SLASH;
            default: return pfe_pkg::CH_PCT;
        endcase
    endfunction

    // Valid postfix with random content; may leave several values on the stack.
    function automatic void build_well_formed(int unsigned wanted, bit leave_extra);
        int unsigned pushed;
        int unsigned held;
        pushed = 0;
        held   = 0;
        while (pushed < wanted) begin
            if (held >= 2 && $urandom_range(0, 1) == 1) begin
                expr_chars.push_back(random_operator());
                held--;
            end else begin
                expr_chars.push_back(random_operand());
                pushed++;
                held++;
            end
        end
        while (!leave_extra && held > 1) begin
            expr_chars.push_back(random_operator());
            held--;
        end
    endfunction

    // 64^5 * 2 wraps to the most negative word, then 0 - 1 gives the divisor -1.
    function automatic void build_most_negative(bit use_mod);
        logic [pfe_pkg::SYM_W-1:0] sixty_four;
        sixty_four = pfe_pkg::CH_LO_A + 8'd15;
        expr_chars.push_back(sixty_four);
        repeat (4) begin
            expr_chars.push_back(sixty_four);
            expr_chars.push_back(pfe_pkg::CH_STAR);
        end
        expr_chars.push_back(pfe_pkg::CH_ZERO + 8'd2);
        expr_chars.push_back(pfe_pkg::CH_STAR);
        expr_chars.push_back(pfe_pkg::CH_ZERO);
        expr_chars.push_back(pfe_pkg::CH_ZERO + 8'd1);
        expr_chars.push_back(pfe_pkg::CH_MINUS);
        expr_chars.push_back(use_mod ? pfe_pkg::CH_PCT : pfe_pkg::CH_SLASH);
    endfunction

    function automatic void build_stack_fill(int unsigned count);
        repeat (count) expr_chars.push_back(random_operand());
        repeat (count - 1) expr_chars.push_back(random_operator());
    endfunction

    initial begin
        int unsigned round;
        int unsigned r;
        exprs_sent = 0;
        ready_hold = 0;
        steady     = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed expressions: symbol extremes, every operator, the bad character, underflow and
        // division-by-zero errors, the sticky error and a stack left with more than one value.
        expr_chars = '{8'h00};                                    send_expression();
        expr_chars = '{8'hFF};                                    send_expression();
        expr_chars = '{pfe_pkg::CH_PLUS};                         send_expression();
        expr_chars = '{pfe_pkg::CH_LO_Z, pfe_pkg::CH_ZERO, pfe_pkg::CH_SLASH};
        send_expression();
        expr_chars = '{pfe_pkg::CH_UP_Z, pfe_pkg::CH_ZERO, pfe_pkg::CH_PCT};
        send_expression();
        expr_chars = '{pfe_pkg::CH_LO_Z, pfe_pkg::CH_NINE, pfe_pkg::CH_PCT};
        send_expression();
        expr_chars = '{pfe_pkg::CH_ZERO, pfe_pkg::CH_LO_Z, pfe_pkg::CH_MINUS,
                       pfe_pkg::CH_NINE, pfe_pkg::CH_SLASH};
        send_expression();
        expr_chars = '{pfe_pkg::CH_UP_A, pfe_pkg::CH_NINE, pfe_pkg::CH_STAR,
                       pfe_pkg::CH_LO_Z, pfe_pkg::CH_PLUS};
        send_expression();
        expr_chars = '{pfe_pkg::CH_NINE, 8'h20, pfe_pkg::CH_PLUS}; send_expression();
        expr_chars = '{pfe_pkg::CH_ZERO, pfe_pkg::CH_NINE};         send_expression();

        // Random expressions. The first rounds pin down the wrap of the most
        // negative value and the full and overflowing stack.
        round = 0;
        while (board.accepted_requests < TARGET_REQUESTS) begin
            case (round)
                0: build_most_negative(1'b0);
                1: build_most_negative(1'b1);
                2: build_stack_fill(pfe_pkg::STACK_DEPTH + 1);
                3: build_stack_fill(pfe_pkg::STACK_DEPTH);
                default: begin
                    r = $urandom % 100;
                    if (r < 72) begin
                        build_well_formed(($urandom % 8 == 0) ? $urandom_range(7, 16)
                                                              : $urandom_range(1, 6),
                                          $urandom % 8 == 0);
                    end else if (r < 84) begin
                        build_well_formed($urandom_range(2, 6), 1'b0);
                        expr_chars.insert($urandom_range(0, expr_chars.size() - 1),
                                          ($urandom_range(0, 1) == 1) ? random_operator()
                                                                      : 8'($urandom));
                    end else if (r < 92) begin
                        repeat ($urandom_range(1, 5)) expr_chars.push_back(8'($urandom));
                    end else if (r < 96) begin
                        build_most_negative($urandom_range(0, 1) == 1);
                    end else begin
                        repeat ($urandom_range(1, 8)) begin
                            expr_chars.push_back(($urandom_range(0, 1) == 1)
                                                 ? random_operator() : random_operand());
                        end
                    end
                end
            endcase
            send_expression();
            round++;
        end
        s_tvalid <= 1'b0;

        while (board.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        $display("Sent %0d expressions in %0d requests, %0d characters evaluated; %0d results.",
                 exprs_sent, board.accepted_requests, board.live_symbols, board.results_seen);
        $display("Results by status: ok %0d, bad char %0d, underflow %0d, overflow %0d, div0 %0d.",
                 board.status_hits[0], board.status_hits[1], board.status_hits[2],
                 board.status_hits[3], board.status_hits[4]);
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(64'd20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: postfix_expression_evaluator.f
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_div.sv
hw/rtl/postfix_expression_evaluator.sv
tb/sv/testbench.sv
